// ===== hw/rtl/tpa_pkg.sv =====
// Shared types, constants and the arctangent table for the tilt persistence alarm.
package tpa_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_FILTER_FRAC_BITS = 8;
	localparam int DEF_ANGLE_ITERATIONS = 16;
	localparam int DEF_SAMPLE_WIDTH     = 16;

	// Fixed field and register widths
	localparam int RAW_W    = 16;
	localparam int ANGLE_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;
	localparam int ALPHA_W  = 9;
	localparam int MS_W     = 16;

	// Angle scale: 1/256 degree
	localparam int ANGLE_90  = 23040;
	localparam int ANGLE_180 = 46080;

	// Arctangent table: 1/65536 degree per unit
	localparam int ATAN_W     = 22;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_ACC_W = 25;

	// Register reset values
	localparam int RST_FILTER_ALPHA    = 51;
	localparam int RST_ANGLE_THRESHOLD = 6400;
	localparam int RST_HOLD_TIME_MS    = 3000;
	localparam int RST_BLINK_PERIOD_MS = 100;
	localparam int ALPHA_ONE           = 256;
	localparam int FZ_RESET_G          = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ALPHA    = 2'd0,
		REG_ANGLE_THRESHOLD = 2'd1,
		REG_HOLD_TIME_MS    = 2'd2,
		REG_BLINK_PERIOD_MS = 2'd3
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_TICK   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_item_t;

	typedef struct packed {
		logic        alarm_on;
		logic        indicator_level;
		logic        slouching;
		logic [15:0] roll_angle;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FY_MUL,
		ST_FY_ACC,
		ST_FZ_MUL,
		ST_FZ_ACC,
		ST_CORDIC_INIT,
		ST_CORDIC_ITER,
		ST_COMMIT_TICK,
		ST_COMMIT_SAMPLE
	} state_t;

	typedef struct packed {
		logic load;
		logic filt_mul;
		logic filt_acc;
		logic sel_z;
		logic cordic_init;
		logic cordic_step;
		logic commit_tick;
		logic commit_sample;
	} cmd_t;

	typedef struct packed {
		logic in_op;
		logic special;
		logic iter_last;
		logic out_free;
	} sts_t;

	function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117266;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/tpa_ctrl.sv =====
// Controller state machine sequencing filter, CORDIC and commit steps.
module tpa_ctrl import tpa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = (sts.in_op == OP_SAMPLE) ? ST_FY_MUL : ST_COMMIT_TICK;
				end
			end
			ST_FY_MUL: begin
				cmd.filt_mul = 1'b1;
				state_n      = ST_FY_ACC;
			end
			ST_FY_ACC: begin
				cmd.filt_acc = 1'b1;
				state_n      = ST_FZ_MUL;
			end
			ST_FZ_MUL: begin
				cmd.filt_mul = 1'b1;
				cmd.sel_z    = 1'b1;
				state_n      = ST_FZ_ACC;
			end
			ST_FZ_ACC: begin
				cmd.filt_acc = 1'b1;
				cmd.sel_z    = 1'b1;
				state_n      = ST_CORDIC_INIT;
			end
			ST_CORDIC_INIT: begin
				cmd.cordic_init = 1'b1;
				// skip rotation for axis-aligned or zero vectors
				state_n = sts.special ? ST_COMMIT_SAMPLE : ST_CORDIC_ITER;
			end
			ST_CORDIC_ITER: begin
				cmd.cordic_step = 1'b1;
				if (sts.iter_last) begin
					state_n = ST_COMMIT_SAMPLE;
				end
			end
			ST_COMMIT_TICK: begin
				if (sts.out_free) begin
					cmd.commit_tick = 1'b1;
					state_n         = ST_IDLE;
				end
			end
			ST_COMMIT_SAMPLE: begin
				if (sts.out_free) begin
					cmd.commit_sample = 1'b1;
					state_n           = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/tpa_datapath.sv =====
// Datapath: registers, shared EMA multiplier, CORDIC unit, alarm timers, result register.
module tpa_datapath import tpa_pkg::*; #(
	parameter int FILTER_FRAC_BITS = DEF_FILTER_FRAC_BITS,
	parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS,
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output out_item_t            out_data,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int FW  = SAMPLE_WIDTH + FILTER_FRAC_BITS;
	localparam int DW  = FW + 1;
	localparam int PW  = FW + 11;
	localparam int SA  = FW + 12;
	localparam int CW  = FW + 2;
	localparam int AW  = ATAN_ACC_W;
	localparam int IW  = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
	localparam int SMAX_I = (1 << (SAMPLE_WIDTH - 1)) - 1;
	localparam int SMIN_I = -SMAX_I - 1;
	localparam logic signed [RAW_W-1:0] SMAX = RAW_W'(SMAX_I);
	localparam logic signed [RAW_W-1:0] SMIN = RAW_W'(SMIN_I);
	localparam logic signed [SA-1:0] FMAX = {{(SA-FW+1){1'b0}}, {(FW-1){1'b1}}};
	localparam logic signed [SA-1:0] FMIN = {{(SA-FW+1){1'b1}}, {(FW-1){1'b0}}};
	localparam int FZ_RESET = FZ_RESET_G * (1 << FILTER_FRAC_BITS);

	// configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [ANGLE_W-1:0] thr_q;
	logic [MS_W-1:0]    hold_q;
	logic [MS_W-1:0]    period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_W'(RST_FILTER_ALPHA);
			thr_q    <= ANGLE_W'(RST_ANGLE_THRESHOLD);
			hold_q   <= MS_W'(RST_HOLD_TIME_MS);
			period_q <= MS_W'(RST_BLINK_PERIOD_MS);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILTER_ALPHA:    alpha_q  <= cfg_data[ALPHA_W-1:0];
				REG_ANGLE_THRESHOLD: thr_q    <= cfg_data[ANGLE_W-1:0];
				REG_HOLD_TIME_MS:    hold_q   <= cfg_data[MS_W-1:0];
				REG_BLINK_PERIOD_MS: period_q <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic signed [RAW_W-1:0] raw_y_q;
	logic signed [RAW_W-1:0] raw_z_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_y_q <= in_data.accel_y;
			raw_z_q <= in_data.accel_z;
		end
	end

	// EMA filter: f' = (a*(x - f) + 256*f + 128) >> 8, one axis at a time
	logic signed [FW-1:0]    fy_q;
	logic signed [FW-1:0]    fz_q;
	logic signed [FW-1:0]    f_sel;
	logic signed [RAW_W-1:0] raw_sel;
	logic signed [RAW_W-1:0] raw_sat;
	logic signed [FW-1:0]    x_scaled;
	logic signed [DW-1:0]    diff;
	logic [ALPHA_W-1:0]      alpha_eff;
	logic signed [PW-1:0]    prod_q;
	logic signed [SA-1:0]    ema_sum;
	logic signed [SA-1:0]    ema_shr;
	logic signed [FW-1:0]    ema_next;

	assign f_sel     = cmd.sel_z ? fz_q : fy_q;
	assign raw_sel   = cmd.sel_z ? raw_z_q : raw_y_q;
	assign raw_sat   = (raw_sel > SMAX) ? SMAX : ((raw_sel < SMIN) ? SMIN : raw_sel);
	assign x_scaled  = {raw_sat[SAMPLE_WIDTH-1:0], {FILTER_FRAC_BITS{1'b0}}};
	assign diff      = {x_scaled[FW-1], x_scaled} - {f_sel[FW-1], f_sel};
	assign alpha_eff = (alpha_q > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_q;
	assign ema_sum   = SA'(prod_q) + (SA'(f_sel) <<< 8) + SA'(128);
	assign ema_shr   = ema_sum >>> 8;
	assign ema_next  = (ema_shr > FMAX) ? FMAX[FW-1:0] :
	                   ((ema_shr < FMIN) ? FMIN[FW-1:0] : ema_shr[FW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.filt_mul) begin
			prod_q <= $signed({1'b0, alpha_eff}) * PW'(diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fy_q <= '0;
			fz_q <= FW'(FZ_RESET);
		end else if (cmd.filt_acc) begin
			if (cmd.sel_z) begin
				fz_q <= ema_next;
			end else begin
				fy_q <= ema_next;
			end
		end
	end

	// CORDIC vectoring over (|fz|, |fy|)
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [AW-1:0] acc_q;
	logic [IW-1:0]        idx_q;
	logic signed [CW-1:0] fz_ext;
	logic signed [CW-1:0] fy_ext;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic [ATAN_W-1:0]    tab;
	logic signed [AW-1:0] tab_s;
	logic                 y_zero;
	logic                 x_zero;

	assign fz_ext = CW'(fz_q);
	assign fy_ext = CW'(fy_q);
	assign xs     = x_q >>> idx_q;
	assign ys     = y_q >>> idx_q;
	assign tab    = atan_entry(ATAN_IDX_W'(idx_q));
	assign tab_s  = $signed({{(AW-ATAN_W){1'b0}}, tab});
	assign y_zero = (fy_q == '0);
	assign x_zero = (fz_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			x_q   <= fz_q[FW-1] ? -fz_ext : fz_ext;
			y_q   <= fy_q[FW-1] ? -fy_ext : fy_ext;
			acc_q <= '0;
		end else if (cmd.cordic_step) begin
			if (y_q > 0) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				acc_q <= acc_q + tab_s;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				acc_q <= acc_q - tab_s;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.cordic_init) begin
			idx_q <= '0;
		end else if (cmd.cordic_step) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// angle: round to 1/256 degree, clamp, mirror for negative Z
	logic signed [AW-1:0] acc_rnd;
	logic signed [AW-1:0] base_s;
	logic [ANGLE_W-1:0]   base_clamp;
	logic [ANGLE_W-1:0]   base;
	logic [ANGLE_W-1:0]   angle_new;

	assign acc_rnd = acc_q + AW'(128);
	assign base_s  = acc_rnd >>> 8;

	always_comb begin
		if (base_s < 0) begin
			base_clamp = '0;
		end else if (base_s > AW'(ANGLE_90)) begin
			base_clamp = ANGLE_W'(ANGLE_90);
		end else begin
			base_clamp = base_s[ANGLE_W-1:0];
		end
	end

	assign base      = y_zero ? '0 : (x_zero ? ANGLE_W'(ANGLE_90) : base_clamp);
	assign angle_new = fz_q[FW-1] ? (ANGLE_W'(ANGLE_180) - base) : base;

	// alarm state
	logic               bad_q, alert_q, drive_q;
	logic [MS_W-1:0]    bad_ms_q, tog_ms_q;
	logic [ANGLE_W-1:0] angle_q;
	logic               bad_n, alert_n, drive_n;
	logic [MS_W-1:0]    bad_ms_n, tog_ms_n;
	logic [ANGLE_W-1:0] angle_n;
	logic               commit;

	assign commit = cmd.commit_tick | cmd.commit_sample;

	always_comb begin
		bad_n    = bad_q;
		alert_n  = alert_q;
		drive_n  = drive_q;
		bad_ms_n = bad_ms_q;
		tog_ms_n = tog_ms_q;
		angle_n  = angle_q;
		if (cmd.commit_tick) begin
			if (tog_ms_q != '1) begin
				tog_ms_n = tog_ms_q + MS_W'(1);
			end
			if (bad_q && (bad_ms_q != '1)) begin
				bad_ms_n = bad_ms_q + MS_W'(1);
			end
		end else if (cmd.commit_sample) begin
			angle_n = angle_new;
			if (angle_new > thr_q) begin
				if (!bad_q) begin
					bad_n    = 1'b1;
					bad_ms_n = '0;
				end else if (bad_ms_q > hold_q) begin
					alert_n = 1'b1;
				end
			end else begin
				bad_n    = 1'b0;
				alert_n  = 1'b0;
				drive_n  = 1'b0;
				bad_ms_n = '0;
			end
		end
		if (alert_n && (tog_ms_n >= period_q)) begin
			drive_n  = ~drive_n;
			tog_ms_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q    <= 1'b0;
			alert_q  <= 1'b0;
			drive_q  <= 1'b0;
			bad_ms_q <= '0;
			tog_ms_q <= '0;
			angle_q  <= '0;
		end else if (commit) begin
			bad_q    <= bad_n;
			alert_q  <= alert_n;
			drive_q  <= drive_n;
			bad_ms_q <= bad_ms_n;
			tog_ms_q <= tog_ms_n;
			angle_q  <= angle_n;
		end
	end

	// result register
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.alarm_on        <= alert_n;
			out_q.indicator_level <= drive_n;
			out_q.slouching       <= bad_n;
			out_q.roll_angle      <= angle_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.in_op     = (op_t'(in_data.operation) == OP_SAMPLE);
	assign sts.special   = y_zero | x_zero;
	assign sts.iter_last = (idx_q == IW'(ANGLE_ITERATIONS - 1));
	assign sts.out_free  = ~out_valid_q | out_ready;

endmodule

// ===== hw/rtl/tilt_persistence_alarm_unit.sv =====
// Top level of the tilt persistence alarm: controller plus datapath.
//
//  channel | signals                         | direction | transaction
//  --------+---------------------------------+-----------+--------------------------------
//  in      | in_valid, in_ready, in_data     | input     | one tick or one Y/Z sample
//  out     | out_valid, out_ready, out_data  | output    | one alarm status per input item
//  cfg     | cfg_valid, cfg_ready, cfg_index,| input     | one register write
//          | cfg_data                        |           |
//
// A tick takes the controller through accept and commit. A sample takes it
// through accept, multiply and accumulate per filter axis on the shared EMA
// multiplier, CORDIC set-up, one step per rotation and commit; zero or
// axis-aligned vectors skip the rotations. The result is registered at the commit.
// Reset restores the register defaults, the filter state and the alarm timers.
// A full output register stalls the commit; the next item is taken once the
// controller returns to idle, even while the last result waits to be taken.
module tilt_persistence_alarm_unit import tpa_pkg::*; #(
	parameter int FILTER_FRAC_BITS = DEF_FILTER_FRAC_BITS,
	parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS,
	parameter int SAMPLE_WIDTH     = DEF_SAMPLE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// take register writes in every cycle
	assign cfg_ready = 1'b1;

	tpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpa_datapath #(
		.FILTER_FRAC_BITS (FILTER_FRAC_BITS),
		.ANGLE_ITERATIONS (ANGLE_ITERATIONS),
		.SAMPLE_WIDTH     (SAMPLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== test/tilt_alarm_check.sv =====
// Checker for the tilt persistence alarm: predicts each status item and compares it.
module tilt_alarm_check import tpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC     = DEF_FILTER_FRAC_BITS;
	localparam int     ITERS    = DEF_ANGLE_ITERATIONS;
	localparam int     FILT_W   = DEF_SAMPLE_WIDTH + DEF_FILTER_FRAC_BITS;
	localparam longint FILT_MAX = (longint'(1) <<< (FILT_W - 1)) - 1;
	localparam longint FILT_MIN = -FILT_MAX - 1;
	localparam int     MS_TOP   = 65535;

	// arctangent of 2^-i in 1/65536 degree
	longint atan_step_deg [0:15] = '{
		2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	logic [ALPHA_W-1:0] alpha_r;
	logic [15:0]        thresh_r, hold_r, period_r;
	longint             filt_y, filt_z;
	logic [15:0]        angle_r;
	bit                 bad_r, alert_r, drive_r;
	int                 bad_ms, blink_ms;
	out_item_t          status_q [$];

	function automatic longint ema_next(longint f, logic signed [15:0] raw);
		longint a, acc, q;
		a = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha_r);
		acc = a * (longint'(raw) * (longint'(1) <<< FRAC)) + (ALPHA_ONE - a) * f + 128;
		q = acc >>> 8;
		if (q > FILT_MAX) q = FILT_MAX;
		if (q < FILT_MIN) q = FILT_MIN;
		return q;
	endfunction

	// Vectoring rotation over the folded first quadrant, then unfold for negative Z
	function automatic logic [15:0] roll_from(longint fy, longint fz);
		longint x, y, xs, ys, acc, base;
		int i;
		x = (fz < 0) ? -fz : fz;
		y = (fy < 0) ? -fy : fy;
		if (y == 0) begin
			base = 0;
		end else if (x == 0) begin
			base = ANGLE_90;
		end else begin
			acc = 0;
			for (i = 0; i < ITERS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					acc = acc + atan_step_deg[i];
				end else begin
					x = x - ys;
					y = y + xs;
					acc = acc - atan_step_deg[i];
				end
			end
			base = (acc + 128) >>> 8;
			if (base < 0) base = 0;
			if (base > ANGLE_90) base = ANGLE_90;
		end
		if (fz < 0) base = ANGLE_180 - base;
		return base[15:0];
	endfunction

	task automatic advance_alarm(in_item_t it);
		out_item_t want;
		if (op_t'(it.operation) == OP_TICK) begin
			if (blink_ms < MS_TOP) blink_ms++;
			if (bad_r && bad_ms < MS_TOP) bad_ms++;
		end else begin
			filt_y = ema_next(filt_y, it.accel_y);
			filt_z = ema_next(filt_z, it.accel_z);
			angle_r = roll_from(filt_y, filt_z);
			if (angle_r > thresh_r) begin
				if (!bad_r) begin
					bad_r = 1'b1;
					bad_ms = 0;
				end else if (bad_ms > hold_r) begin
					alert_r = 1'b1;
				end
			end else begin
				bad_r = 1'b0;
				alert_r = 1'b0;
				drive_r = 1'b0;
				bad_ms = 0;
			end
		end
		if (alert_r && blink_ms >= period_r) begin
			drive_r = !drive_r;
			blink_ms = 0;
		end
		want.alarm_on = alert_r;
		want.indicator_level = drive_r;
		want.slouching = bad_r;
		want.roll_angle = angle_r;
		status_q.push_back(want);
	endtask

	task automatic note_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			alpha_r = ALPHA_W'(RST_FILTER_ALPHA);
			thresh_r = 16'(RST_ANGLE_THRESHOLD);
			hold_r = 16'(RST_HOLD_TIME_MS);
			period_r = 16'(RST_BLINK_PERIOD_MS);
			filt_y = 0;
			filt_z = longint'(FZ_RESET_G) <<< FRAC;
			angle_r = '0;
			bad_r = 1'b0;
			alert_r = 1'b0;
			drive_r = 1'b0;
			bad_ms = 0;
			blink_ms = 0;
			status_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_FILTER_ALPHA:    alpha_r = cfg_data[ALPHA_W-1:0];
					REG_ANGLE_THRESHOLD: thresh_r = cfg_data;
					REG_HOLD_TIME_MS:    hold_r = cfg_data;
					REG_BLINK_PERIOD_MS: period_r = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					note_mismatch("result with nothing pending, roll_angle", out_data.roll_angle, 0);
				end else begin
					want = status_q.pop_front();
					if (out_data.alarm_on !== want.alarm_on)
						note_mismatch("alarm_on", out_data.alarm_on, want.alarm_on);
					if (out_data.indicator_level !== want.indicator_level)
						note_mismatch("indicator_level", out_data.indicator_level,
							want.indicator_level);
					if (out_data.slouching !== want.slouching)
						note_mismatch("slouching", out_data.slouching, want.slouching);
					if (out_data.roll_angle !== want.roll_angle)
						note_mismatch("roll_angle", out_data.roll_angle, want.roll_angle);
				end
			end
			if (in_valid && in_ready)
				advance_alarm(in_data);
			pending <= status_q.size();
		end
	end

endmodule

// ===== test/tilt_persistence_alarm_unit_tb.sv =====
// Testbench top for the tilt persistence alarm: stimulus, receiver pacing and verdict.
module tilt_persistence_alarm_unit_tb;
	import tpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatches;
	int pending;

	// Pacing controls used by the sender and the receiver processes
	bit paced;
	bit steady;
	int burst_left;
	int hold_offs_wanted;
	int hold_offs_done;

	tilt_persistence_alarm_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tilt_alarm_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// Hard stop: the slowest legal run is well under a tenth of this.
	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

	// Receiver: long hold-offs on request, otherwise random stall runs
	// mixed with free-running stretches. Steady mode keeps ready high.
	initial begin : status_sink
		int stall_left;
		int free_left;
		stall_left = 0;
		free_left = 0;
		forever begin
			@(posedge clk);
			if (hold_offs_done < hold_offs_wanted) begin
				// hold ready low long enough for the output register and the input to back up
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_offs_done++;
				out_ready <= 1'b1;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (free_left > 0) begin
				free_left--;
				out_ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					stall_left = $urandom_range(1, 6);
					out_ready <= 1'b0;
				end else begin
					free_left = $urandom_range(1, 40);
					out_ready <= 1'b1;
				end
			end
		end
	end

	function automatic in_item_t sample_item(int y, int z);
		in_item_t it;
		it.operation = OP_SAMPLE;
		it.accel_y = y[15:0];
		it.accel_z = z[15:0];
		return it;
	endfunction

	// Ticks carry random payload bits; the block must ignore them.
	function automatic in_item_t tick_item();
		in_item_t it;
		it.operation = OP_TICK;
		it.accel_y = 16'($urandom);
		it.accel_z = 16'($urandom);
		return it;
	endfunction

	// Upright samples sit near the Z axis, slumped ones lean far over;
	// a fifth of them are raw noise over the whole field range.
	function automatic in_item_t posture_sample(bit slumped);
		int y, z;
		if ($urandom_range(0, 4) == 0) begin
			y = $urandom;
			z = $urandom;
		end else if (slumped) begin
			y = $urandom_range(2000, 24000);
			z = int'($urandom_range(0, 24000)) - 8000;
		end else begin
			y = $urandom_range(0, 1500);
			z = $urandom_range(3000, 16000);
		end
		if ($urandom_range(0, 1) == 1) y = -y;
		return sample_item(y, z);
	endfunction

	// Present one item and hold it until the transaction completes.
	// When paced, insert a gap at the end of each burst.
	task automatic offer(in_item_t it);
		if (paced) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 24))
					@(posedge clk);
				burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 10);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic offer_ticks(int n);
		int k;
		for (k = 0; k < n; k++)
			offer(tick_item());
	endtask

	// Drop valid and wait until every predicted status item has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all four registers back to back; only call while the block is idle.
	task automatic write_regs(logic [CFG_W-1:0] alpha, logic [CFG_W-1:0] thresh,
			logic [CFG_W-1:0] hold, logic [CFG_W-1:0] period);
		put_reg(REG_FILTER_ALPHA, alpha);
		put_reg(REG_ANGLE_THRESHOLD, thresh);
		put_reg(REG_HOLD_TIME_MS, hold);
		put_reg(REG_BLINK_PERIOD_MS, period);
		cfg_valid <= 1'b0;
	endtask

	// Mostly ticks with posture samples between them; the posture flips now and
	// then so bad stretches run long enough to pass the hold time and blink.
	task automatic run_phase(int n, int tick_pct);
		bit slumped;
		int k;
		slumped = 1'b0;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 39) == 0) slumped = !slumped;
			if ($urandom_range(0, 99) < tick_pct)
				offer(tick_item());
			else
				offer(posture_sample(slumped));
		end
		settle();
	endtask

	initial begin : stimulus
		int p;
		paced = 1'b1;
		steady = 1'b0;
		burst_left = 0;
		hold_offs_wanted = 0;
		hold_offs_done = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset
		offer(tick_item());
		offer(sample_item(0, 256));
		offer(sample_item(4000, 256));
		offer(tick_item());
		settle();

		// Transparent filter (upper data bits are dropped), short hold, blink on every item
		write_regs(16'hFF00, 16'd6400, 16'd2, 16'd0);
		offer(sample_item(0, 0));              // zero vector
		offer(sample_item(1000, 0));           // Z vertical, first bad sample
		offer_ticks(3);
		offer(sample_item(-32768, 0));         // past the hold: alert
		offer_ticks(2);
		offer(sample_item(0, -5000));          // flat Y, upside down
		offer(sample_item(32767, 32767));
		offer(sample_item(-32768, -32768));
		offer(sample_item(0, 32767));          // upright: clear everything
		offer(sample_item(32767, -32768));
		offer(sample_item(1, 32767));
		offer(sample_item(-1, -1));
		offer(tick_item());
		settle();

		// Longest hold, alpha above one acting as one: no alert may be raised.
		steady = 1'b1;
		paced = 1'b0;
		write_regs(16'h01FF, 16'd0, 16'd65535, 16'd65535);
		offer(sample_item(100, 100));
		offer_ticks(40);
		offer(sample_item(100, 100));
		settle();
		// Short hold: the timer already exceeds it, so the next bad sample alerts
		write_regs(16'h01FF, 16'd0, 16'd2, 16'd65535);
		offer_ticks(3);
		offer(sample_item(100, 100));
		settle();
		steady = 1'b0;
		paced = 1'b1;

		// Random phases over a spread of settings, extremes included
		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_regs(16'd256, 16'd6400, 16'd5, 16'd0);
				1: write_regs(16'd1, 16'd2560, 16'd0, 16'd3);
				2: write_regs(16'd511, 16'($urandom_range(0, 23040)),
					16'($urandom_range(0, 20)), 16'd1);
				3: write_regs(16'd0, 16'd0, 16'($urandom_range(0, 10)),
					16'($urandom_range(0, 8)));
				4: write_regs(16'($urandom), 16'd46080, 16'($urandom_range(0, 20)),
					16'd65535);
				default: write_regs(16'($urandom_range(128, 256)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 30)),
					16'($urandom_range(0, 50)));
			endcase
			// back up the whole pipe twice during the run
			if (p == 0 || p == 4) hold_offs_wanted++;
			run_phase(250, (p == 3) ? 50 : 70);
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
